// File: sv/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants of the triangle unit-normal pipeline
// Widths of the normalized magnitudes, the squared sum and the root, and the
// side-band structures that travel with an item through the square-root and
// division pipelines.
// ----------------------------------------------------------------------------
package tun_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int NORM_FRAC_BITS_DEF = 14;
    localparam int OUT_BITS           = 16;

    // the largest magnitude after normalization lies in [2^29, 2^30), unless all are zero
    localparam int MAG_W  = 30;
    localparam int SQ_W   = 2 * MAG_W + 2;
    localparam int ROOT_W = SQ_W / 2;

    typedef logic [MAG_W-1:0] mag_t;

    typedef struct packed {
        logic       deg;
        logic [2:0] neg;
    } tun_flags_t;

    typedef struct packed {
        tun_flags_t      flags;
        logic [2:0][MAG_W-1:0] mag;
    } tun_side_t;

endpackage

// File: sv/tun_isqrt.sv
// ----------------------------------------------------------------------------
// tun_isqrt: pipelined integer square root
// One result bit per register stage, digit by digit from the top, with the
// item's side-band carried along unchanged.
// ----------------------------------------------------------------------------
module tun_isqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [tun_pkg::SQ_W-1:0]    sq,
    input  tun_pkg::tun_side_t          in_side,
    output logic                        out_vld,
    output logic [tun_pkg::ROOT_W-1:0]  root,
    output tun_pkg::tun_side_t          out_side
);
    import tun_pkg::*;

    localparam int RW = ROOT_W + 2;

    logic              vld_w  [ROOT_W+1];
    logic [RW-1:0]     rem_w  [ROOT_W+1];
    logic [ROOT_W-1:0] root_w [ROOT_W+1];
    logic [SQ_W-1:0]   rest_w [ROOT_W+1];
    tun_side_t         side_w [ROOT_W+1];

    assign vld_w[0]  = in_vld;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign rest_w[0] = sq;
    assign side_w[0] = in_side;

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [RW+1:0]     r2;
        logic [RW+1:0]     trial;
        logic              ge;
        logic              vld_reg;
        logic [RW-1:0]     rem_reg;
        logic [ROOT_W-1:0] root_reg;
        logic [SQ_W-1:0]   rest_reg;
        tun_side_t         side_reg;

        always_comb
        begin
            r2    = {rem_w[k], rest_w[k][SQ_W-1 -: 2]};
            trial = {2'b00, root_w[k], 2'b01};
            ge    = (r2 >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= ge ? RW'(r2 - trial) : RW'(r2);
                root_reg <= {root_w[k][ROOT_W-2:0], ge};
                rest_reg <= rest_w[k] << 2;
                side_reg <= side_w[k];
            end
        end

        assign vld_w[k+1]  = vld_reg;
        assign rem_w[k+1]  = rem_reg;
        assign root_w[k+1] = root_reg;
        assign rest_w[k+1] = rest_reg;
        assign side_w[k+1] = side_reg;
    end

    assign out_vld  = vld_w[ROOT_W];
    assign root     = root_w[ROOT_W];
    assign out_side = side_w[ROOT_W];

endmodule

// File: sv/tun_div.sv
// ----------------------------------------------------------------------------
// tun_div: three-lane pipelined rounding divider
// Divides (mag * 2^frac + root/2) by root in each lane, one quotient bit
// per register stage after a preparation stage.
// ----------------------------------------------------------------------------
module tun_div #(
    parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_vld,
    input  logic [2:0][tun_pkg::MAG_W-1:0]       mag,
    input  logic [tun_pkg::ROOT_W-1:0]           root,
    input  tun_pkg::tun_flags_t                  in_flags,
    output logic                                 out_vld,
    output logic [2:0][NORM_FRAC_BITS:0]         quo,
    output tun_pkg::tun_flags_t                  out_flags
);
    import tun_pkg::*;

    localparam int Q  = NORM_FRAC_BITS + 1;
    localparam int DW = MAG_W + NORM_FRAC_BITS + 1;

    logic                   vld_w   [Q+1];
    logic [2:0][ROOT_W-1:0] rem_w   [Q+1];
    logic [2:0][Q-1:0]      dl_w    [Q+1];
    logic [2:0][Q-1:0]      qt_w    [Q+1];
    logic [ROOT_W-1:0]      l_w     [Q+1];
    tun_flags_t             flags_w [Q+1];

    // preparation: form the rounded dividend, split it at the quotient width
    logic [2:0][DW-1:0]     div_next;
    logic                   p_vld_reg;
    logic [2:0][ROOT_W-1:0] p_rem_reg;
    logic [2:0][Q-1:0]      p_dl_reg;
    logic [ROOT_W-1:0]      p_l_reg;
    tun_flags_t             p_flags_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            div_next[l] = {1'b0, mag[l], {NORM_FRAC_BITS{1'b0}}} + DW'(root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                p_rem_reg[l] <= ROOT_W'(div_next[l][DW-1:Q]);
                p_dl_reg[l]  <= div_next[l][Q-1:0];
            end
            p_l_reg     <= root;
            p_flags_reg <= in_flags;
        end
    end

    assign vld_w[0]   = p_vld_reg;
    assign rem_w[0]   = p_rem_reg;
    assign dl_w[0]    = p_dl_reg;
    assign qt_w[0]    = '0;
    assign l_w[0]     = p_l_reg;
    assign flags_w[0] = p_flags_reg;

    for (genvar k = 0; k < Q; k++)
    begin : g_stage
        logic [2:0][ROOT_W:0]   r2;
        logic [2:0]             ge;
        logic                   vld_reg;
        logic [2:0][ROOT_W-1:0] rem_reg;
        logic [2:0][Q-1:0]      dl_reg;
        logic [2:0][Q-1:0]      qt_reg;
        logic [ROOT_W-1:0]      l_reg;
        tun_flags_t             flags_reg;

        always_comb
        begin
            for (int l = 0; l < 3; l++)
            begin
                r2[l] = {rem_w[k][l], dl_w[k][l][Q-1]};
                ge[l] = (r2[l] >= {1'b0, l_w[k]});
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= vld_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rem_reg[l] <= ge[l] ? ROOT_W'(r2[l] - {1'b0, l_w[k]}) : ROOT_W'(r2[l]);
                    dl_reg[l]  <= dl_w[k][l] << 1;
                    qt_reg[l]  <= {qt_w[k][l][Q-2:0], ge[l]};
                end
                l_reg     <= l_w[k];
                flags_reg <= flags_w[k];
            end
        end

        assign vld_w[k+1]   = vld_reg;
        assign rem_w[k+1]   = rem_reg;
        assign dl_w[k+1]    = dl_reg;
        assign qt_w[k+1]    = qt_reg;
        assign l_w[k+1]     = l_reg;
        assign flags_w[k+1] = flags_reg;
    end

    assign out_vld   = vld_w[Q];
    assign quo       = qt_w[Q];
    assign out_flags = flags_w[Q];

endmodule

// File: sv/triangle_unit_normal.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of a triangle, fixed point
// Edges, cross product, normalization to unit length in signed Q1.14.
// ----------------------------------------------------------------------------
// One triangle transfer per clock while the pipeline is not held, one result
// transfer per triangle, in order. The stages are edges, partial products,
// cross product, normalize, squares, sum, square root, divider preparation,
// divider and, last, the output register. Depth is set by the square root
// (one result bit per stage) and the three-lane divider (one quotient bit per
// stage). The whole pipeline holds when a result waits at the output while
// out_stall is high, and it advances freely while the output register is empty.
// A triangle whose cross product is zero (collinear or coincident vertices)
// returns degenerate = 1 and zero components. A component beyond the 16-bit
// output saturates to +/-32767.
module triangle_unit_normal #(
    parameter int COORD_BITS     = tun_pkg::COORD_BITS_DEF,
    parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [COORD_BITS-1:0]        a_x,
    input  logic signed [COORD_BITS-1:0]        a_y,
    input  logic signed [COORD_BITS-1:0]        a_z,
    input  logic signed [COORD_BITS-1:0]        b_x,
    input  logic signed [COORD_BITS-1:0]        b_y,
    input  logic signed [COORD_BITS-1:0]        b_z,
    input  logic signed [COORD_BITS-1:0]        c_x,
    input  logic signed [COORD_BITS-1:0]        c_y,
    input  logic signed [COORD_BITS-1:0]        c_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [tun_pkg::OUT_BITS-1:0] unit_x,
    output logic signed [tun_pkg::OUT_BITS-1:0] unit_y,
    output logic signed [tun_pkg::OUT_BITS-1:0] unit_z,
    output logic                                degenerate
);
    import tun_pkg::*;

    localparam int CB    = COORD_BITS;
    // edge width; wide coordinates drop low edge bits so products fit
    localparam int E     = (CB > 30) ? 31 : CB + 1;
    localparam int ESH   = (CB > 30) ? CB - 30 : 0;
    localparam int PW    = 2 * E;
    localparam int W     = (PW > MAG_W) ? PW : MAG_W;
    localparam int NS    = $clog2(W);
    localparam int Q     = NORM_FRAC_BITS + 1;
    localparam logic [31:0] LIM = 32'((1 << (OUT_BITS - 1)) - 1);

    // global advance: move everything unless a result is held at the output
    logic en;
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    // ------------------------------------------------------------------
    // Stage 1: edge vectors v = b - a (0..2), w = c - a (3..5)
    // ------------------------------------------------------------------
    logic [CB-1:0]         pt [9];
    logic signed [E-1:0]   ed_next [6];
    logic signed [E-1:0]   ed_reg  [6];
    logic                  e_vld_reg;

    assign pt[0] = a_x;
    assign pt[1] = a_y;
    assign pt[2] = a_z;
    assign pt[3] = b_x;
    assign pt[4] = b_y;
    assign pt[5] = b_z;
    assign pt[6] = c_x;
    assign pt[7] = c_y;
    assign pt[8] = c_z;

    for (genvar k = 0; k < 6; k++)
    begin : g_edge
        localparam int HI = (k < 3) ? k + 3 : k + 3;
        localparam int LO = (k < 3) ? k : k - 3;
        logic [CB:0] d;
        logic [CB:0] dm;
        logic [CB:0] dms;
        logic [CB:0] ev;

        always_comb
        begin
            d   = {pt[HI][CB-1], pt[HI]} - {pt[LO][CB-1], pt[LO]};
            dm  = d[CB] ? (~d + 1'b1) : d;
            // truncate toward zero on the magnitude
            dms = dm >> ESH;
            ev  = d[CB] ? (~dms + 1'b1) : dms;
            ed_next[k] = $signed(ev[E-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (en)
            e_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            ed_reg <= ed_next;
    end

    // ------------------------------------------------------------------
    // Stage 2: six partial products of the cross product
    // ------------------------------------------------------------------
    logic signed [PW-1:0] pr_reg [6];
    logic                 p_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_vld_reg <= 1'b0;
        else if (en)
            p_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg[0] <= ed_reg[1] * ed_reg[5];   // vy*wz
            pr_reg[1] <= ed_reg[2] * ed_reg[4];   // vz*wy
            pr_reg[2] <= ed_reg[2] * ed_reg[3];   // vz*wx
            pr_reg[3] <= ed_reg[0] * ed_reg[5];   // vx*wz
            pr_reg[4] <= ed_reg[0] * ed_reg[4];   // vx*wy
            pr_reg[5] <= ed_reg[1] * ed_reg[3];   // vy*wx
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: cross product, split into sign and magnitude
    // ------------------------------------------------------------------
    logic [2:0][PW-1:0] cm_next;
    logic [2:0]         cn_next;
    logic [2:0][PW-1:0] cm_reg;
    logic [2:0]         cn_reg;
    logic               c_vld_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [PW:0] n;
            logic [PW:0] a;
            n = {pr_reg[2*l][PW-1], pr_reg[2*l]} - {pr_reg[2*l+1][PW-1], pr_reg[2*l+1]};
            a = n[PW] ? (~n + 1'b1) : n;
            cn_next[l] = n[PW];
            cm_next[l] = a[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= p_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_reg <= cm_next;
            cn_reg <= cn_next;
        end
    end

    // ------------------------------------------------------------------
    // Normalize: left-align the largest magnitude, one shift step a stage.
    // The top 30 bits then hold the largest magnitude scaled into [2^29, 2^30).
    // ------------------------------------------------------------------
    logic              nv_w [NS+1];
    logic [2:0][W-1:0] nm_w [NS+1];
    logic [2:0]        nn_w [NS+1];

    assign nv_w[0] = c_vld_reg;
    assign nn_w[0] = cn_reg;
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            nm_w[0][l] = W'(cm_reg[l]);
        end
    end

    for (genvar k = 0; k < NS; k++)
    begin : g_norm
        localparam int SH = 1 << (NS - 1 - k);
        logic [W-1:0]      any;
        logic              shift;
        logic              vld_reg;
        logic [2:0][W-1:0] m_reg;
        logic [2:0]        n_reg;

        always_comb
        begin
            any   = nm_w[k][0] | nm_w[k][1] | nm_w[k][2];
            shift = ~|any[W-1 -: SH];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= nv_w[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    m_reg[l] <= shift ? (nm_w[k][l] << SH) : nm_w[k][l];
                end
                n_reg <= nn_w[k];
            end
        end

        assign nv_w[k+1] = vld_reg;
        assign nm_w[k+1] = m_reg;
        assign nn_w[k+1] = n_reg;
    end

    // ------------------------------------------------------------------
    // Squares of the normalized magnitudes, then their sum
    // ------------------------------------------------------------------
    logic [2:0][MAG_W-1:0]   mg;
    logic [2:0][2*MAG_W-1:0] sq_reg;
    tun_side_t               q_side_reg;
    logic                    q_vld_reg;
    logic [SQ_W-1:0]         sum_reg;
    tun_side_t               s_side_reg;
    logic                    s_vld_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mg[l] = nm_w[NS][l][W-1 -: MAG_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q_vld_reg <= nv_w[NS];
            s_vld_reg <= q_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                sq_reg[l] <= mg[l] * mg[l];
            end
            q_side_reg.mag       <= mg;
            q_side_reg.flags.neg <= nn_w[NS];
            // nothing left after alignment means a zero cross product
            q_side_reg.flags.deg <= ~|(mg[0] | mg[1] | mg[2]);
            sum_reg    <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            s_side_reg <= q_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Length, then each magnitude over the length
    // ------------------------------------------------------------------
    logic              r_vld;
    logic [ROOT_W-1:0] r_root;
    tun_side_t         r_side;

    tun_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s_vld_reg),
        .sq       (sum_reg),
        .in_side  (s_side_reg),
        .out_vld  (r_vld),
        .root     (r_root),
        .out_side (r_side)
    );

    logic              d_vld;
    logic [2:0][Q-1:0] d_quo;
    tun_flags_t        d_flags;

    tun_div #(
        .NORM_FRAC_BITS (NORM_FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_vld    (r_vld),
        .mag       (r_side.mag),
        .root      (r_root),
        .in_flags  (r_side.flags),
        .out_vld   (d_vld),
        .quo       (d_quo),
        .out_flags (d_flags)
    );

    // ------------------------------------------------------------------
    // Output register: saturate, apply sign, zero a degenerate result
    // ------------------------------------------------------------------
    logic [2:0][OUT_BITS-1:0] u_next;
    logic                     out_valid_reg;
    logic [2:0][OUT_BITS-1:0] u_reg;
    logic                     deg_reg;

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            logic [31:0] qe;
            logic [31:0] qs;
            qe = 32'(d_quo[l]);
            qs = (qe > LIM) ? LIM : qe;
            if (d_flags.deg)
                u_next[l] = '0;
            else if (d_flags.neg[l])
                u_next[l] = ~qs[OUT_BITS-1:0] + 1'b1;
            else
                u_next[l] = qs[OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= d_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg   <= u_next;
            deg_reg <= d_flags.deg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign unit_x     = $signed(u_reg[0]);
    assign unit_y     = $signed(u_reg[1]);
    assign unit_z     = $signed(u_reg[2]);
    assign degenerate = deg_reg;

endmodule

// File: sim/tun_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tun_checker: result checker of the triangle unit-normal pipeline
// Watches both channels, computes the expected normal of every accepted
// triangle and compares each result transfer with the oldest one in order.
// ----------------------------------------------------------------------------
module tun_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [15:0] unit_x, unit_y, unit_z,
    input  logic               degenerate,
    output int                 errors,
    output int                 pending
);

    typedef struct packed {
        logic signed [15:0] ux, uy, uz;
        logic               deg;
    } normal_t;

    normal_t normals_due[$];

    function automatic logic [63:0] root_floor(logic [63:0] x);
        logic [63:0] res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic normal_t face_normal(
        longint ax, ay, az, bx, by, bz, cx, cy, cz);
        longint     vx, vy, vz, wx, wy, wz;
        longint     n[3];
        logic [63:0] m[3];
        logic [63:0] mx, s, len, q;
        logic [2:0] neg;
        logic signed [15:0] r[3];
        normal_t    res;
        vx = bx - ax; vy = by - ay; vz = bz - az;
        wx = cx - ax; wy = cy - ay; wz = cz - az;
        n[0] = vy * wz - vz * wy;
        n[1] = vz * wx - vx * wz;
        n[2] = vx * wy - vy * wx;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = n[i] < 0;
            m[i]   = neg[i] ? -n[i] : n[i];
            if (m[i] > mx)
                mx = m[i];
        end
        if (mx == 0)
        begin
            res = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
            return res;
        end
        while (mx >= (64'd1 << 30))
        begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 29))
        begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        s   = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << 14) + (len >> 1)) / len;
            if (q > 32767)
                q = 32767;
            r[i] = neg[i] ? -q[15:0] : q[15:0];
        end
        res = '{r[0], r[1], r[2], 1'b0};
        return res;
    endfunction

    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (normals_due.size() == 0)
                begin
                    $display("%0t: result with none due: got %0d %0d %0d deg %0d",
                             $time, unit_x, unit_y, unit_z, degenerate);
                    errors++;
                end
                else
                begin
                    want = normals_due.pop_front();
                    if (want !== {unit_x, unit_y, unit_z, degenerate})
                    begin
                        $display("%0t: expected %0d %0d %0d deg %0d, got %0d %0d %0d deg %0d",
                                 $time, want.ux, want.uy, want.uz, want.deg,
                                 unit_x, unit_y, unit_z, degenerate);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                normals_due.insert(normals_due.size(),
                                   face_normal(a_x, a_y, a_z, b_x, b_y, b_z,
                                               c_x, c_y, c_z));
            pending = normals_due.size();
        end
    end

endmodule

// File: sim/tb_triangle_unit_normal.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_unit_normal: stimulus and verdict for the unit-normal pipeline
// Drives directed and random triangles under several idle and stall mixes,
// including a long output hold-off; a checker module scores every result.
// ----------------------------------------------------------------------------
module tb_triangle_unit_normal;

    localparam int WATCHDOG = 20000;

    logic clk, rst_n;
    logic in_valid, in_stall, out_valid, out_stall, degenerate;
    logic signed [15:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
    logic signed [15:0] unit_x, unit_y, unit_z;
    int   errors, pending;
    int   idle_pct, stall_pct;   // chance in a hundred, per cycle
    bit   hold_off;              // long receiver hold-off in progress
    int   quiet;                 // cycles with no transfer on either side

    triangle_unit_normal dut (.*);

    tun_checker chk (.*);

    always
    begin
        clk = 1'b0; #5;
        clk = 1'b1; #5;
    end

    // Receiver: stall at random, or hold for a long stretch on request.
    always @(negedge clk)
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);

    // Watchdog: count cycles with no transfer at all.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Offer one triangle, then hold it until the block takes it.
    // Valid stays high afterwards so the next triangle can follow directly.
    task automatic send_triangle(input logic [15:0] v[9]);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} <=
            {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Pick a random triangle; mostly full range, some small, collinear or at the extremes.
    task automatic random_triangle(output logic [15:0] v[9]);
        int shape;
        int k;
        shape = $urandom_range(9);
        for (int i = 0; i < 9; i++)
            v[i] = 16'($urandom);
        if (shape == 0)
            for (int i = 3; i < 9; i++)
                v[i] = 16'(v[i % 3] + $urandom_range(7) - 3);
        else if (shape == 1)
        begin
            // c = a + k*(b - a): collinear when nothing wraps
            k = $urandom_range(4);
            for (int i = 0; i < 3; i++)
            begin
                v[i + 3] = 16'(v[i] + ($urandom_range(255) - 128));
                v[i + 6] = 16'(v[i] + k * (v[i + 3] - v[i]));
            end
        end
        else if (shape == 2)
            for (int i = 0; i < 9; i++)
                v[i] = $urandom_range(1) ? 16'h8000 : 16'h7fff;
    endtask

    initial
    begin
        logic [15:0] tri_v[9];
        logic [15:0] ext[4];
        ext = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        rst_n = 1'b0; in_valid = 1'b0; hold_off = 1'b0;
        idle_pct = 0; stall_pct = 0;
        {a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z} = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: coincident, collinear, axis-aligned, extremes.
        tri_v = '{default: 16'h0};
        send_triangle(tri_v);
        tri_v = '{16'h0100, 16'h0200, 16'h0300, 16'h0200, 16'h0400, 16'h0600,
                  16'h0300, 16'h0600, 16'h0900};
        send_triangle(tri_v);
        tri_v = '{0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100, 0};
        send_triangle(tri_v);
        tri_v = '{0, 0, 0, 0, 16'h0100, 0, 0, 0, 16'h0100};
        send_triangle(tri_v);
        tri_v = '{0, 0, 0, 0, 0, 16'h0100, 16'h0100, 0, 0};
        send_triangle(tri_v);
        tri_v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        send_triangle(tri_v);
        for (int i = 0; i < 16; i++)
        begin
            for (int j = 0; j < 9; j++)
                tri_v[j] = ext[(i + j * (i / 4 + 1)) % 4];
            send_triangle(tri_v);
        end

        // Random phases: no idling, sender idle, receiver stall, both.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = (ph == 1) ? 56 : (ph == 3) ? 27 : 0;
            stall_pct = (ph == 2) ? 56 : (ph == 3) ? 27 : 0;
            for (int n = 0; n < 370; n++)
            begin
                random_triangle(tri_v);
                send_triangle(tri_v);
            end
        end

        // Hold the output off long enough for the pipeline to fill.
        idle_pct = 0; stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
            end
            for (int n = 0; n < 100; n++)
            begin
                random_triangle(tri_v);
                send_triangle(tri_v);
            end
        join
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
